// ----- rtl/core/lcd_window_pixel_spi_writer_assert.svh -----
// assertion macros for the lcd window writer checker
// no dependencies
`ifndef LCD_WINDOW_PIXEL_SPI_WRITER_ASSERT_SVH
`define LCD_WINDOW_PIXEL_SPI_WRITER_ASSERT_SVH

// next-cycle implication, ignored while reset is held
`define LCDWIN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lcdwin assertion failed");

// next-cycle implication, also checked through reset
`define LCDWIN_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lcdwin assertion failed");

`endif

// ----- rtl/core/lcdwin_pkg.sv -----
// types, constants and helpers for the lcd window and pixel spi writer
// no dependencies
package lcdwin_pkg;

  localparam int unsigned SCREEN_SIZE = 128;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [6:0] SCROLL_SRC_ROW = 7'd120;
  localparam logic [6:0] SCROLL_DST_ROW = 7'd112;
  localparam logic [4:0] SCROLL_STEP    = 5'd2;

  localparam logic [8:0] DATA_BIT = 9'h100;

  localparam logic [7:0] COLUMN_SET_RST   = 8'd21;
  localparam logic [7:0] PAGE_SET_RST     = 8'd117;
  localparam logic [7:0] MEMORY_WRITE_RST = 8'd92;
  localparam logic [7:0] SCROLL_START_RST = 8'd171;
  localparam logic       SCROLL_EN_RST    = 1'b1;

  localparam logic [2:0] WINDOW_WORDS = 3'd7;
  localparam logic [2:0] SHORT_WORDS  = 3'd2;

  typedef enum logic [1:0] {
    CMD_WINDOW = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_COLUMN_SET   = 3'd0,
    CFG_PAGE_SET     = 3'd1,
    CFG_MEMORY_WRITE = 3'd2,
    CFG_SCROLL_START = 3'd3,
    CFG_SCROLL_EN    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_SCROLL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [6:0] src_row;
    logic [6:0] dst_row;
  } in_item_t;

  typedef struct packed {
    logic [8:0] spi_word;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] column_set_opcode;
    logic [7:0] page_set_opcode;
    logic [7:0] memory_write_opcode;
    logic [7:0] scroll_start_opcode;
    logic       scroll_enable;
  } cfg_regs_t;

  // queued job: window uses all four bytes, pixel and scroll the first ones
  typedef struct packed {
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } job_t;

  function automatic logic [8:0] data_word(input logic [7:0] b);
    return DATA_BIT | {1'b0, b};
  endfunction

  function automatic logic [8:0] cmd_word(input logic [7:0] b);
    return {1'b0, b};
  endfunction

endpackage

// ----- rtl/core/lcdwin_front.sv -----
// front end: accepts items, checks windows, packs pixels, tracks scroll state
// depends on lcdwin_pkg
module lcdwin_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  lcdwin_pkg::in_item_t  item,
  input  logic                  scroll_enable,
  output logic                  push,
  output lcdwin_pkg::job_t      job
);
  import lcdwin_pkg::*;

  logic [4:0] scroll_block_r, scroll_block_nxt;
  logic       in_bottom_r, in_bottom_nxt;
  logic [8:0] x_end_sum, y_end_sum;
  logic       win_ok;

  assign x_end_sum = {1'b0, item.x_start} + {1'b0, item.width};
  assign y_end_sum = {1'b0, item.y_start} + {1'b0, item.height};

  assign win_ok = ({1'b0, item.x_start} <= 9'(SCREEN_SIZE))
               && ({1'b0, item.y_start} <= 9'(SCREEN_SIZE))
               && (x_end_sum <= 9'(SCREEN_SIZE))
               && (y_end_sum <= 9'(SCREEN_SIZE))
               && (item.width != 8'd0) && (item.height != 8'd0);

  always_comb begin
    push             = 1'b0;
    job              = '0;
    scroll_block_nxt = scroll_block_r;
    in_bottom_nxt    = in_bottom_r;
    case (item.cmd)
      CMD_WINDOW: begin
        job.kind = KIND_WINDOW;
        job.b0   = item.x_start;
        job.b1   = x_end_sum[7:0] - 8'd1;
        job.b2   = item.y_start;
        job.b3   = y_end_sum[7:0] - 8'd1;
        push     = win_ok;
      end
      CMD_PIXEL: begin
        job.kind = KIND_PIXEL;
        job.b0   = {4'b0, item.red[7:4]};
        job.b1   = {item.green[7:4], item.blue[7:4]};
        push     = 1'b1;
      end
      CMD_SCROLL: begin
        job.kind = KIND_SCROLL;
        if (scroll_enable) begin
          if (item.src_row == SCROLL_SRC_ROW) begin
            if (item.dst_row == SCROLL_DST_ROW && !in_bottom_r) begin
              scroll_block_nxt = scroll_block_r + SCROLL_STEP;
              in_bottom_nxt    = 1'b1;
              push             = 1'b1;
            end
          end else begin
            in_bottom_nxt = 1'b0;
          end
        end
        job.b0 = {3'b0, scroll_block_nxt};
      end
      default: begin
        push = 1'b0;
      end
    endcase
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_block_r <= '0;
      in_bottom_r    <= 1'b0;
    end else if (accept) begin
      scroll_block_r <= scroll_block_nxt;
      in_bottom_r    <= in_bottom_nxt;
    end
  end

endmodule

// ----- rtl/core/lcdwin_fifo.sv -----
// short job queue between the front end and the word sequencer
// depends on lcdwin_pkg
module lcdwin_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcdwin_pkg::job_t  push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output lcdwin_pkg::job_t  head_job
);
  import lcdwin_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/core/lcdwin_back.sv -----
// word sequencer: expands queued jobs into 9-bit spi words, one per cycle while out_stall is low
// depends on lcdwin_pkg
module lcdwin_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcdwin_pkg::cfg_regs_t  cfg,
  input  logic                   head_valid,
  input  lcdwin_pkg::job_t       head_job,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lcdwin_pkg::out_item_t  out_data
);
  import lcdwin_pkg::*;

  localparam logic [2:0] W_COL_OP   = 3'd0;
  localparam logic [2:0] W_X_START  = 3'd1;
  localparam logic [2:0] W_X_END    = 3'd2;
  localparam logic [2:0] W_PAGE_OP  = 3'd3;
  localparam logic [2:0] W_Y_START  = 3'd4;
  localparam logic [2:0] W_Y_END    = 3'd5;

  logic       busy_r, busy_nxt;
  job_t       cur_r, cur_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  job_t       job;
  logic [2:0] idx;
  logic [2:0] n_words;
  logic [8:0] word;
  logic       adv, have_job, is_last;

  assign adv      = !out_valid_r || !out_stall;
  assign have_job = busy_r || head_valid;
  assign job      = busy_r ? cur_r : head_job;
  assign idx      = busy_r ? idx_r : 3'd0;
  assign n_words  = (job.kind == KIND_WINDOW) ? WINDOW_WORDS : SHORT_WORDS;
  assign is_last  = (idx == n_words - 3'd1);
  assign pop      = adv && !busy_r && head_valid;

  always_comb begin
    case (job.kind)
      KIND_WINDOW: begin
        case (idx)
          W_COL_OP:  word = cmd_word(cfg.column_set_opcode);
          W_X_START: word = data_word(job.b0);
          W_X_END:   word = data_word(job.b1);
          W_PAGE_OP: word = cmd_word(cfg.page_set_opcode);
          W_Y_START: word = data_word(job.b2);
          W_Y_END:   word = data_word(job.b3);
          default:   word = cmd_word(cfg.memory_write_opcode);
        endcase
      end
      KIND_PIXEL: begin
        word = (idx == 3'd0) ? data_word(job.b0) : data_word(job.b1);
      end
      KIND_SCROLL: begin
        word = (idx == 3'd0) ? cmd_word(cfg.scroll_start_opcode) : data_word(job.b0);
      end
      default: begin
        word = '0;
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt = have_job;
      if (have_job) begin
        out_data_nxt.spi_word = word;
        out_data_nxt.last     = is_last;
        busy_nxt              = !is_last;
        idx_nxt               = idx + 3'd1;
        cur_nxt               = job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/lcd_window_pixel_spi_writer.sv -----
// first word is registered after the job queue; one word per cycle while not stalled
// a pixel or a scroll sends 2 words, a window 7, from the single-word output sequencer
// items that send no words queue no job; a QUEUE_DEPTH-job queue decouples input and output
// synchronous active-low reset empties the queue and output, clears scroll state
// and returns the opcode and scroll-enable registers to their defaults
// depends on lcdwin_pkg, lcdwin_front, lcdwin_fifo, lcdwin_back
module lcd_window_pixel_spi_writer #(
  parameter int unsigned QUEUE_DEPTH = lcdwin_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lcdwin_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lcdwin_pkg::out_item_t  out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [7:0]             cfg_wdata
);
  import lcdwin_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      in_accept;
  logic      push, pop, full, head_valid;
  job_t      push_job, head_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMN_SET:   cfg_nxt.column_set_opcode   = cfg_wdata;
        CFG_PAGE_SET:     cfg_nxt.page_set_opcode     = cfg_wdata;
        CFG_MEMORY_WRITE: cfg_nxt.memory_write_opcode = cfg_wdata;
        CFG_SCROLL_START: cfg_nxt.scroll_start_opcode = cfg_wdata;
        CFG_SCROLL_EN:    cfg_nxt.scroll_enable       = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_set_opcode   <= COLUMN_SET_RST;
      cfg_r.page_set_opcode     <= PAGE_SET_RST;
      cfg_r.memory_write_opcode <= MEMORY_WRITE_RST;
      cfg_r.scroll_start_opcode <= SCROLL_START_RST;
      cfg_r.scroll_enable       <= SCROLL_EN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcdwin_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .item          (in_data),
    .scroll_enable (cfg_r.scroll_enable),
    .push          (push),
    .job           (push_job)
  );

  lcdwin_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lcdwin_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/core/lcdwin_checker.sv -----
// port-level checks for the lcd window writer, bound to the top level
// depends on lcdwin_pkg and lcd_window_pixel_spi_writer_assert.svh
`include "lcd_window_pixel_spi_writer_assert.svh"

module lcdwin_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input lcdwin_pkg::out_item_t  out_data
);
  import lcdwin_pkg::*;

  `LCDWIN_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)

  `LCDWIN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // a command word that is not the last of its burst is followed at once by data
  `LCDWIN_ASSERT_NEXT(a_cmd_then_data, clk, rst_n, out_valid && !out_stall && !out_data.spi_word[8] && !out_data.last, out_valid && out_data.spi_word[8])

endmodule

bind lcd_window_pixel_spi_writer lcdwin_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
